[rtl/broken_down_time_to_epoch_unit_assert.svh]
// Assertion macros for the broken-down time to epoch unit.
// Included by the top level; no other dependencies.
`ifndef BROKEN_DOWN_TIME_TO_EPOCH_UNIT_ASSERT_SVH
`define BROKEN_DOWN_TIME_TO_EPOCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BDTE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bdte assertion failed");
`define BDTE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) \
		else $error("bdte assertion failed");
`else
`define BDTE_ASSERT(label, clk, rst_n, prop)
`define BDTE_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

[rtl/bdte_pkg.sv]
// Shared types, constants and calendar tables for the epoch unit.
// No dependencies.
package bdte_pkg;
	localparam int InW  = 72;
	localparam int OutW = 88;
	localparam logic [11:0] YearBase = 12'd1900;
	localparam logic [11:0] EpochYear = 12'd1970;
	localparam logic [9:0] MinYear = 10'd70;
	localparam logic [9:0] LeapBase = 10'd477;

	typedef enum logic [3:0] {
		OP_IDLE, OP_LOAD, OP_DIV_GO, OP_DIV_TAKE, OP_WALK, OP_YDAY,
		OP_FIN1, OP_FIN2, OP_FIN3, OP_PUBLISH
	} dp_op_t;

	typedef enum logic [2:0] {
		SEL_SEC, SEL_MIN, SEL_HR, SEL_MON, SEL_Y100, SEL_Y400, SEL_WD
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_more;
		logic yday_more;
		logic out_free;
	} dp_stat_t;

	function automatic logic [4:0] days_in(input logic leap, input logic [3:0] m);
		logic [4:0] n;
		unique case (m)
			4'd1: n = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] dow_off(input logic [3:0] m);
		logic [2:0] o;
		unique case (m)
			4'd0: o = 3'd0;
			4'd1: o = 3'd3;
			4'd2: o = 3'd2;
			4'd3: o = 3'd5;
			4'd4: o = 3'd0;
			4'd5: o = 3'd3;
			4'd6: o = 3'd5;
			4'd7: o = 3'd1;
			4'd8: o = 3'd4;
			4'd9: o = 3'd6;
			4'd10: o = 3'd2;
			default: o = 3'd4;
		endcase
		return o;
	endfunction
endpackage

[rtl/bdte_div.sv]
// Constant divider by reciprocal multiplication: the quotient is registered,
// then the remainder from it. Depends on nothing.
module bdte_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] dividend,
	input  logic [8:0]  divisor,
	output logic        done,
	output logic [15:0] quo,
	output logic [8:0]  rem
);
	logic [1:0]  phase_q;
	logic        done_q;
	logic [15:0] num_q;
	logic [8:0]  den_q;
	logic [21:0] recip_q;
	logic [15:0] quo_q;
	logic [8:0]  rem_q;
	logic [21:0] recip;
	logic [37:0] prod;
	logic [24:0] back;
	logic [15:0] diff;

	// ceil(2^24 / d); exact for 16-bit dividends, for 400 up to 43690
	always_comb begin
		unique case (divisor)
			9'd7:    recip = 22'd2396746;
			9'd12:   recip = 22'd1398102;
			9'd24:   recip = 22'd699051;
			9'd60:   recip = 22'd279621;
			9'd100:  recip = 22'd167773;
			9'd400:  recip = 22'd41944;
			default: recip = '0;
		endcase
	end

	assign prod = num_q * recip_q;
	assign back = quo_q * den_q;
	assign diff = num_q - back[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				phase_q <= 2'd1;
			end else if (phase_q == 2'd1) begin
				phase_q <= 2'd2;
			end else if (phase_q == 2'd2) begin
				phase_q <= 2'd0;
				done_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q   <= dividend;
			den_q   <= divisor;
			recip_q <= recip;
		end
		if (phase_q == 2'd1) begin
			quo_q <= 16'(prod[37:24]);
		end
		if (phase_q == 2'd2) begin
			rem_q <= diff[8:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

[rtl/bdte_dp.sv]
// Datapath: field registers, carry divisions, month walk, epoch sum.
// Depends on bdte_pkg and bdte_div.
module bdte_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bdte_pkg::dp_cmd_t         cmd,
	output bdte_pkg::dp_stat_t        stat,
	input  logic [bdte_pkg::InW-1:0]  in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bdte_pkg::OutW-1:0] out_data
);
	import bdte_pkg::*;

	logic [15:0] sec_q;
	logic [12:0] min_q, hr_q;
	logic [10:0] day_q;
	logic [7:0]  mon_q;
	logic [11:0] y_q;
	logic [4:0]  q100_q;
	logic [1:0]  r4_q;
	logic [6:0]  r100_q;
	logic [8:0]  r400_q;
	logic [9:0]  lc_q;
	logic [8:0]  yday_q;
	logic [3:0]  m_q;
	logic [2:0]  wd_q;
	logic [18:0] ydays_q, days_q;
	logic [16:0] tod_q;
	logic [35:0] secs_q;
	logic        out_valid_q;
	logic [OutW-1:0] out_q;

	logic        div_go, div_done;
	logic [15:0] div_a, div_quo;
	logic [8:0]  div_d, div_rem;
	logic [11:0] ym1, wy, wsum;
	logic        leap;
	logic [4:0]  dim, dim_m;
	logic [10:0] hday;
	logic [9:0]  yr_c;

	assign ym1  = y_q - 12'd1;
	assign leap = (r4_q == 2'd3 && r100_q != 7'd99) || r400_q == 9'd399;
	assign dim  = days_in(leap, mon_q[3:0]);
	assign dim_m = days_in(leap, m_q);
	assign wy   = (mon_q[3:0] < 4'd2) ? ym1 : y_q;
	assign wsum = wy + 12'(lc_q) + 12'(mon_q[3:0] >= 4'd2 && leap)
		+ 12'(dow_off(mon_q[3:0])) + 12'(day_q);
	assign hday = day_q + div_quo[10:0];
	assign yr_c = (in_data[67:58] < MinYear) ? MinYear : in_data[67:58];

	always_comb begin
		div_a = '0;
		div_d = 9'd60;
		case (cmd.sel)
			SEL_SEC:  begin div_a = sec_q; div_d = 9'd60; end
			SEL_MIN:  begin div_a = 16'(min_q); div_d = 9'd60; end
			SEL_HR:   begin div_a = 16'(hr_q); div_d = 9'd24; end
			SEL_MON:  begin div_a = 16'(mon_q); div_d = 9'd12; end
			SEL_Y100: begin div_a = 16'(ym1); div_d = 9'd100; end
			SEL_Y400: begin div_a = 16'(ym1); div_d = 9'd400; end
			SEL_WD:   begin div_a = 16'(wsum); div_d = 9'd7; end
			default:  begin div_a = '0; div_d = 9'd60; end
		endcase
	end

	assign div_go = cmd.op == OP_DIV_GO;

	bdte_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_a), .divisor(div_d),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				sec_q <= in_data[15:0];
				min_q <= 13'(in_data[27:16]);
				hr_q  <= 13'(in_data[39:28]);
				day_q <= 11'(in_data[49:40]);
				mon_q <= in_data[57:50];
				y_q   <= YearBase + 12'(yr_c);
			end
			OP_DIV_TAKE: begin
				case (cmd.sel)
					SEL_SEC: begin
						min_q <= min_q + div_quo[12:0];
						sec_q <= 16'(div_rem);
					end
					SEL_MIN: begin
						hr_q  <= hr_q + div_quo[12:0];
						min_q <= 13'(div_rem);
					end
					SEL_HR: begin
						day_q <= (hday == 11'd0) ? 11'd1 : hday;
						hr_q  <= 13'(div_rem);
					end
					SEL_MON: begin
						y_q   <= y_q + div_quo[11:0];
						mon_q <= div_rem[7:0];
					end
					SEL_Y100: begin
						q100_q <= div_quo[4:0];
						r100_q <= div_rem[6:0];
					end
					SEL_Y400: begin
						r400_q <= div_rem;
						r4_q   <= ym1[1:0];
						lc_q   <= ym1[11:2] - 10'(q100_q) + 10'(div_quo[2:0]);
					end
					default: wd_q <= div_rem[2:0];
				endcase
			end
			OP_WALK: begin
				if (day_q > 11'(dim)) begin
					day_q <= day_q - 11'(dim);
					if (mon_q[3:0] == 4'd11) begin
						mon_q  <= '0;
						y_q    <= y_q + 12'd1;
						lc_q   <= lc_q + 10'(leap);
						r4_q   <= r4_q + 2'd1;
						r100_q <= (r100_q == 7'd99) ? 7'd0 : r100_q + 7'd1;
						r400_q <= (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
					end else begin
						mon_q <= mon_q + 8'd1;
					end
				end else begin
					yday_q <= 9'(day_q);
					m_q    <= '0;
				end
			end
			OP_YDAY: begin
				if (m_q < mon_q[3:0]) begin
					yday_q <= yday_q + 9'(dim_m);
					m_q    <= m_q + 4'd1;
				end
			end
			OP_FIN1: begin
				ydays_q <= 19'(19'd365 * 19'(y_q - EpochYear));
				tod_q   <= 17'(17'd60 * 17'(min_q[5:0])) + 17'(sec_q[5:0]);
			end
			OP_FIN2: begin
				tod_q  <= tod_q + 17'(17'd3600 * 17'(hr_q[4:0]));
				days_q <= ydays_q + 19'(lc_q - LeapBase) + 19'(yday_q) - 19'd1;
			end
			OP_FIN3: secs_q <= 36'(36'd86400 * 36'(days_q)) + 36'(tod_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_PUBLISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			out_q <= {3'd0, secs_q, yday_q, wd_q, 11'(y_q - YearBase), mon_q[3:0],
				day_q[4:0], hr_q[4:0], min_q[5:0], sec_q[5:0]};
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_q;
	assign stat.div_done  = div_done;
	assign stat.walk_more = day_q > 11'(dim);
	assign stat.yday_more = m_q < mon_q[3:0];
	assign stat.out_free  = !out_valid_q || out_ready;
endmodule

[rtl/bdte_ctrl.sv]
// Controller state machine sequencing the epoch datapath.
// Depends on bdte_pkg.
module bdte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdte_pkg::dp_stat_t stat,
	output bdte_pkg::dp_cmd_t  cmd
);
	import bdte_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DGO   = 9'b000000010,
		S_DWAIT = 9'b000000100,
		S_WALK  = 9'b000001000,
		S_YDAY  = 9'b000010000,
		S_FIN1  = 9'b000100000,
		S_FIN2  = 9'b001000000,
		S_FIN3  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t   state_q, state_d;
	div_sel_t sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd.op  = OP_IDLE;
		cmd.sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					sel_d   = SEL_SEC;
					state_d = S_DGO;
				end
			end
			S_DGO: begin
				cmd.op  = OP_DIV_GO;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_DIV_TAKE;
					unique case (sel_q)
						SEL_SEC:  begin sel_d = SEL_MIN; state_d = S_DGO; end
						SEL_MIN:  begin sel_d = SEL_HR; state_d = S_DGO; end
						SEL_HR:   begin sel_d = SEL_MON; state_d = S_DGO; end
						SEL_MON:  begin sel_d = SEL_Y100; state_d = S_DGO; end
						SEL_Y100: begin sel_d = SEL_Y400; state_d = S_DGO; end
						SEL_Y400: state_d = S_WALK;
						default:  state_d = S_FIN1;
					endcase
				end
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (!stat.walk_more) state_d = S_YDAY;
			end
			S_YDAY: begin
				cmd.op = OP_YDAY;
				if (!stat.yday_more) begin
					sel_d   = SEL_WD;
					state_d = S_DGO;
				end
			end
			S_FIN1: begin
				cmd.op  = OP_FIN1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.op  = OP_FIN2;
				state_d = S_FIN3;
			end
			S_FIN3: begin
				cmd.op  = OP_FIN3;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= SEL_SEC;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign in_ready = state_q == S_IDLE;
endmodule

[rtl/broken_down_time_to_epoch_unit.sv]
// Top level of the broken-down time to epoch seconds unit.
// Depends on bdte_pkg, bdte_ctrl, bdte_dp and the assertion header.
//
// Usage: one input transaction on s_axis carries a calendar time whose
// fields may overflow; one output transaction on m_axis returns the
// normalized fields, weekday, day of year and seconds since 1970.
// Items are handled one at a time. Between the accepting edge and
// m_axis_tvalid the unit runs seven divisions (six carries and the weekday)
// in a shared reciprocal-multiply divider, each as start, quotient,
// remainder, take; a month walk of one month per cycle; a day-of-year sum of
// one month per cycle; epoch arithmetic in S_FIN1, S_FIN2 and S_FIN3; and a
// publish step. s_axis_tready is high only while the unit is idle, so the
// next input can be accepted in the cycle after the publish step.
// The finished result sits in an output register, so the next input is
// taken while it waits; a stalled m_axis holds the unit at its final step
// until the register frees. Reset clears the controller and the output
// valid; no memory needs clearing.
`include "broken_down_time_to_epoch_unit_assert.svh"
module broken_down_time_to_epoch_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// sec_in[15:0] min_in[27:16] hour_in[39:28] mday_in[49:40] month_in[57:50]
	// year_in[67:58]
	input  logic [bdte_pkg::InW-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// sec_out[5:0] min_out[11:6] hour_out[16:12] mday_out[21:17]
	// month_out[25:22] year_out[36:26] weekday[39:37] year_day[48:40]
	// epoch_seconds[84:49]
	output logic [bdte_pkg::OutW-1:0] m_axis_tdata
);
	import bdte_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bdte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	bdte_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

	`BDTE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`BDTE_ASSERT(a_time_norm, clk, arst_n, !m_axis_tvalid || (m_axis_tdata[5:0] < 6'd60 && m_axis_tdata[11:6] < 6'd60 && m_axis_tdata[16:12] < 5'd24))
	`BDTE_ASSERT(a_date_norm, clk, arst_n, !m_axis_tvalid || (m_axis_tdata[25:22] < 4'd12 && m_axis_tdata[21:17] != 5'd0 && m_axis_tdata[39:37] < 3'd7))
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for broken_down_time_to_epoch_unit: directed and random
// calendar times, bursty input traffic and a receiver that stalls, checked in order.
// Depends on bdte_pkg and the RTL of the unit.
module tb_top;
	import bdte_pkg::*;

	typedef struct packed {
		logic [9:0]  year;
		logic [7:0]  month;
		logic [9:0]  mday;
		logic [11:0] hour;
		logic [11:0] min;
		logic [15:0] sec;
	} cal_in_t;

	typedef struct packed {
		logic [35:0] epoch;
		logic [8:0]  yday;
		logic [2:0]  wday;
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [4:0]  hour;
		logic [5:0]  min;
		logic [5:0]  sec;
	} cal_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [InW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OutW-1:0] m_axis_tdata;

	cal_in_t  pending_times[$];
	cal_out_t expected_dates[$];
	cal_in_t  cur_time;
	int unsigned errors = 0;
	int unsigned taken = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	logic hold_done = 1'b0;

	broken_down_time_to_epoch_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		int unsigned lens[12];
		lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		return lens[m] + ((m == 1 && leap_year(y)) ? 1 : 0);
	endfunction

	function automatic int unsigned leaps_upto(int unsigned y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic cal_out_t normalize_time(cal_in_t t);
		int unsigned offs[12];
		int unsigned sec, mins, hrs, day, mon, y, wy, yday;
		longint unsigned secs;
		cal_out_t r;
		offs = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		y = ((t.year < 70) ? 70 : t.year) + 1900;
		sec = t.sec; mins = t.min; hrs = t.hour; day = t.mday; mon = t.month;
		mins += sec / 60; sec %= 60;
		hrs += mins / 60; mins %= 60;
		day += hrs / 24; hrs %= 24;
		if (day == 0) day = 1;
		y += mon / 12; mon %= 12;
		while (day > month_days(y, mon)) begin
			day -= month_days(y, mon);
			mon++;
			if (mon >= 12) begin
				mon = 0;
				y++;
			end
		end
		wy = (mon < 2) ? y - 1 : y;
		r.wday = 3'((wy + wy / 4 - wy / 100 + wy / 400 + offs[mon] + day) % 7);
		yday = day;
		for (int m = 0; m < mon; m++) yday += month_days(y, m);
		secs = longint'(sec) + 60 * longint'(mins) + 3600 * longint'(hrs);
		secs += 64'd86400 * (yday - 1);
		secs += 64'd86400 * 365 * (y - 1970);
		secs += 64'd86400 * (leaps_upto(y - 1) - leaps_upto(1969));
		r.sec = 6'(sec); r.min = 6'(mins); r.hour = 5'(hrs); r.mday = 5'(day);
		r.month = 4'(mon); r.year = 11'(y - 1900); r.yday = 9'(yday);
		r.epoch = secs[35:0];
		return r;
	endfunction

	function automatic cal_in_t mk_time(int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi, int unsigned s);
		cal_in_t t;
		t.year = 10'(y); t.month = 8'(mo); t.mday = 10'(d);
		t.hour = 12'(h); t.min = 12'(mi); t.sec = 16'(s);
		return t;
	endfunction

	initial begin
		cal_in_t t;
		pending_times.push_back(mk_time(70, 0, 1, 0, 0, 0));
		pending_times.push_back(mk_time(1023, 255, 1023, 4095, 4095, 65535));
		pending_times.push_back(mk_time(0, 0, 0, 0, 0, 0));
		pending_times.push_back(mk_time(69, 11, 31, 23, 59, 59));
		pending_times.push_back(mk_time(70, 0, 0, 23, 59, 59));
		pending_times.push_back(mk_time(70, 0, 0, 24, 0, 0));
		pending_times.push_back(mk_time(100, 1, 29, 0, 0, 0));
		pending_times.push_back(mk_time(200, 1, 29, 12, 0, 0));
		pending_times.push_back(mk_time(500, 1, 29, 0, 0, 0));
		pending_times.push_back(mk_time(124, 1, 30, 0, 0, 0));
		pending_times.push_back(mk_time(99, 11, 31, 23, 59, 60));
		pending_times.push_back(mk_time(70, 12, 1, 0, 0, 0));
		pending_times.push_back(mk_time(70, 255, 1, 0, 0, 0));
		pending_times.push_back(mk_time(138, 0, 19, 3, 14, 7));
		pending_times.push_back(mk_time(1023, 11, 31, 23, 59, 59));
		pending_times.push_back(mk_time(512, 128, 512, 2048, 2048, 32768));
		pending_times.push_back(mk_time(70, 0, 1023, 0, 0, 0));
		for (int i = 0; i < 700; i++) begin
			t = 68'({$urandom, $urandom, $urandom});
			if ($urandom_range(0, 2) == 0) begin
				t.year = 10'($urandom_range(60, 140));
				t.month = 8'($urandom_range(0, 13));
				t.mday = 10'($urandom_range(0, 32));
				t.hour = 12'($urandom_range(0, 25));
				t.min = 12'($urandom_range(0, 61));
				t.sec = 16'($urandom_range(0, 61));
			end
			pending_times.push_back(t);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				expected_dates.push_back(normalize_time(cur_time));
				taken <= taken + 1;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_times.size() > 0) begin
				cur_time = pending_times.pop_front();
				s_axis_tdata <= {4'b0, cur_time};
				s_axis_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && taken >= 60) begin
			hold_done <= 1'b1;
			hold_left <= 3000;
			m_axis_tready <= 1'b0;
		end else if (taken % 200 < 50) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cal_out_t got;
		cal_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[84:0];
			if (expected_dates.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transaction: %h", got);
			end else begin
				want = expected_dates.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (pending_times.size() != 0 || s_axis_tvalid || expected_dates.size() != 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_dates.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/bdte_pkg.sv
rtl/bdte_div.sv
rtl/bdte_dp.sv
rtl/bdte_ctrl.sv
rtl/broken_down_time_to_epoch_unit.sv
test/tb_top.sv
